// ===== rtl/xml_entity_decoder_top_assert.svh =====
// assertion macros for the xml entity decoder
// used by xml_entity_decoder_top; expects aclk and aresetn in scope
`ifndef XML_ENTITY_DECODER_TOP_ASSERT_SVH
`define XML_ENTITY_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define XED_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("xml entity decoder check failed");
`define XED_ASSERT_HOLDS(name, cond) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("xml entity decoder check failed");
`else
`define XED_ASSERT_IMPLY(name, ante, cons)
`define XED_ASSERT_HOLDS(name, cond)
`endif
`endif

// ===== rtl/xed_pkg.sv =====
// shared types and character codes for the xml entity decoder
// no dependencies
package xed_pkg;

    localparam int RESULT_CAP = 16;
    localparam int EMIT_W     = $clog2(RESULT_CAP + 1);

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_APOS = 8'h27;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LB   = 8'h62;
    localparam logic [7:0] CH_LG   = 8'h67;
    localparam logic [7:0] CH_LL   = 8'h6C;
    localparam logic [7:0] CH_LM   = 8'h6D;
    localparam logic [7:0] CH_LN   = 8'h6E;
    localparam logic [7:0] CH_LO   = 8'h6F;
    localparam logic [7:0] CH_LP   = 8'h70;
    localparam logic [7:0] CH_LQ   = 8'h71;
    localparam logic [7:0] CH_LS   = 8'h73;
    localparam logic [7:0] CH_LT_L = 8'h74;
    localparam logic [7:0] CH_LU   = 8'h75;
    localparam logic [7:0] CH_LX   = 8'h78;
    localparam logic [7:0] CH_UX   = 8'h58;
    localparam logic [7:0] NBSP_HI = 8'hC2;
    localparam logic [7:0] NBSP_LO = 8'hA0;

    localparam logic [31:0] CP_TWO_BYTE   = 32'h80;
    localparam logic [31:0] CP_THREE_BYTE = 32'h800;
    localparam logic [31:0] CP_FOUR_BYTE  = 32'h10000;
    localparam logic [7:0]  LEAD_TWO      = 8'hC0;
    localparam logic [7:0]  LEAD_THREE    = 8'hE0;
    localparam logic [7:0]  LEAD_FOUR     = 8'hF0;
    localparam logic [7:0]  CONT_MARK     = 8'h80;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_NUM  = 8'b0000_0010,
        ST_ENC  = 8'b0000_0100,
        ST_BUF  = 8'b0000_1000,
        ST_AMP  = 8'b0001_0000,
        ST_WIN  = 8'b0010_0000,
        ST_SEMI = 8'b0100_0000,
        ST_COPY = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic clear;
        logic step;
        logic hex;
    } cp_ctrl_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } utf8_t;

endpackage

// ===== rtl/xed_window.sv =====
// scan window register file: one write port, one addressed read, fixed head taps
// uses no package
module xed_window #(
    parameter int DEPTH = 12,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data,
    output logic [3:0][7:0]   head_bytes
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = mem[rd_addr];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            head_bytes[i] = mem[i];
        end
    end

endmodule

// ===== rtl/xed_cp_unit.sv =====
// code point accumulator (one digit a cycle) and utf-8 encoder
// depends on xed_pkg
module xed_cp_unit (
    input  logic              aclk,
    input  xed_pkg::cp_ctrl_t ctrl,
    input  logic [7:0]        digit,
    output xed_pkg::utf8_t    enc
);

    logic [31:0] cp_reg;
    logic [31:0] cp_next;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'h37);
        end
        return v;
    endfunction

    always_comb begin
        cp_next = cp_reg;
        if (ctrl.clear) begin
            cp_next = '0;
        end else if (ctrl.step) begin
            if (ctrl.hex) begin
                cp_next = {cp_reg[27:0], hex_value(digit)};
            end else begin
                cp_next = (cp_reg << 3) + (cp_reg << 1) + {24'd0, digit} - 32'd48;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cp_reg <= cp_next;
    end

    always_comb begin
        enc.bytes = '0;
        enc.len   = 3'd1;
        if (cp_reg < xed_pkg::CP_TWO_BYTE) begin
            enc.bytes[0] = cp_reg[7:0];
            enc.len      = 3'd1;
        end else if (cp_reg < xed_pkg::CP_THREE_BYTE) begin
            enc.bytes[0] = xed_pkg::LEAD_TWO | {3'd0, cp_reg[10:6]};
            enc.bytes[1] = xed_pkg::CONT_MARK | {2'd0, cp_reg[5:0]};
            enc.len      = 3'd2;
        end else if (cp_reg < xed_pkg::CP_FOUR_BYTE) begin
            enc.bytes[0] = xed_pkg::LEAD_THREE | {4'd0, cp_reg[15:12]};
            enc.bytes[1] = xed_pkg::CONT_MARK | {2'd0, cp_reg[11:6]};
            enc.bytes[2] = xed_pkg::CONT_MARK | {2'd0, cp_reg[5:0]};
            enc.len      = 3'd3;
        end else begin
            enc.bytes[0] = xed_pkg::LEAD_FOUR | cp_reg[25:18];
            enc.bytes[1] = xed_pkg::CONT_MARK | {2'd0, cp_reg[17:12]};
            enc.bytes[2] = xed_pkg::CONT_MARK | {2'd0, cp_reg[11:6]};
            enc.bytes[3] = xed_pkg::CONT_MARK | {2'd0, cp_reg[5:0]};
            enc.len      = 3'd4;
        end
    end

endmodule

// ===== rtl/xml_entity_decoder_top.sv =====
// xml character entity decoder with utf-8 output, top level and sequencer
// depends on xed_pkg, xed_window, xed_cp_unit and xml_entity_decoder_top_assert.svh
//
// usage: raw string bytes enter on the s_ channel, one byte per item, with s_tlast on
// the final byte of a string. decoded bytes leave on the m_ channel, m_tlast on the
// final decoded byte of the string.
// a plain byte outside an entity passes straight into the output register.
// bytes after '&' are held in the scan window.
// closing an entity or replaying a failed scan is run by the sequencer, which emits the
// output bytes in turn; a numeric entity first runs its digits through the shared
// accumulator, finishes the sum and then does the utf-8 encoding. a failed scan that finds a
// new '&' steps over it, then moves the bytes behind it to the window front,
// one byte a cycle.
// s_tready is high only when the sequencer is idle and the output register is free
// or being taken, so one item is worked on at a time.
// a stalled receiver holds the output register and the sequencer waits on it, unless the result cap is reached.
// reset (aresetn low, synchronous) leaves the block idle, outside any entity, with the
// window empty and no item pending on m_.
`include "xml_entity_decoder_top_assert.svh"
module xml_entity_decoder_top #(
    parameter int MAX_SCAN = 12
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);

    localparam int IDX_W = $clog2(MAX_SCAN);
    localparam int CNT_W = $clog2(MAX_SCAN + 1);
    localparam int EW    = xed_pkg::EMIT_W;

    xed_pkg::state_t state_reg, state_next;
    logic             in_entity_reg, in_entity_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [IDX_W-1:0] dst_reg, dst_next;
    logic             replay_reg, replay_next;
    logic             last_reg, last_next;
    logic             hex_reg, hex_next;
    logic [EW-1:0]    emit_cnt_reg, emit_cnt_next;
    logic [3:0][7:0]  buf_reg, buf_next;
    logic [2:0]       buf_len_reg, buf_len_next;
    logic [1:0]       bidx_reg, bidx_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [7:0]       m_tdata_reg, m_tdata_next;
    logic             m_tlast_reg, m_tlast_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic [7:0]       rd_data;
    logic [3:0][7:0]  head;

    xed_pkg::cp_ctrl_t cp_ctrl;
    xed_pkg::utf8_t    enc;

    logic       st_idle;
    logic       out_free;
    logic       capped;
    logic       emit_go;
    logic       emit_req;
    logic [7:0] emit_byte;
    logic       emit_final;
    logic       pass_wr;
    logic       s_accept;
    logic       last_idx;
    logic       num_done;
    logic       is_amp, is_lt, is_gt, is_quot, is_apos, is_nbsp;

    xed_window #(
        .DEPTH (MAX_SCAN)
    ) u_window (
        .aclk       (aclk),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_addr    (rd_ptr_reg),
        .rd_data    (rd_data),
        .head_bytes (head)
    );

    xed_cp_unit u_cp (
        .aclk  (aclk),
        .ctrl  (cp_ctrl),
        .digit (rd_data),
        .enc   (enc)
    );

    assign st_idle  = state_reg == xed_pkg::ST_IDLE;
    assign out_free = !m_tvalid_reg || m_tready;
    assign capped   = emit_cnt_reg >= EW'(xed_pkg::RESULT_CAP);
    assign emit_go  = capped || out_free;
    assign s_tready = st_idle && out_free;
    assign s_accept = s_tvalid && s_tready;
    assign last_idx = (CNT_W'(rd_ptr_reg) + CNT_W'(1)) == cnt_reg;
    assign num_done = CNT_W'(rd_ptr_reg) >= cnt_reg;

    assign is_amp  = count_reg == IDX_W'(3) && head[0] == xed_pkg::CH_LA
                     && head[1] == xed_pkg::CH_LM && head[2] == xed_pkg::CH_LP;
    assign is_lt   = count_reg == IDX_W'(2) && head[0] == xed_pkg::CH_LL
                     && head[1] == xed_pkg::CH_LT_L;
    assign is_gt   = count_reg == IDX_W'(2) && head[0] == xed_pkg::CH_LG
                     && head[1] == xed_pkg::CH_LT_L;
    assign is_quot = count_reg == IDX_W'(4) && head[0] == xed_pkg::CH_LQ
                     && head[1] == xed_pkg::CH_LU && head[2] == xed_pkg::CH_LO
                     && head[3] == xed_pkg::CH_LT_L;
    assign is_apos = count_reg == IDX_W'(4) && head[0] == xed_pkg::CH_LA
                     && head[1] == xed_pkg::CH_LP && head[2] == xed_pkg::CH_LO
                     && head[3] == xed_pkg::CH_LS;
    assign is_nbsp = count_reg == IDX_W'(4) && head[0] == xed_pkg::CH_LN
                     && head[1] == xed_pkg::CH_LB && head[2] == xed_pkg::CH_LS
                     && head[3] == xed_pkg::CH_LP;

    always_comb begin
        state_next     = state_reg;
        in_entity_next = in_entity_reg;
        count_next     = count_reg;
        cnt_next       = cnt_reg;
        rd_ptr_next    = rd_ptr_reg;
        dst_next       = dst_reg;
        replay_next    = replay_reg;
        last_next      = last_reg;
        hex_next       = hex_reg;
        emit_cnt_next  = emit_cnt_reg;
        buf_next       = buf_reg;
        buf_len_next   = buf_len_reg;
        bidx_next      = bidx_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;
        wr_en          = 1'b0;
        wr_addr        = count_reg;
        wr_data        = s_tdata;
        cp_ctrl        = '0;
        emit_req       = 1'b0;
        emit_byte      = s_tdata;
        emit_final     = 1'b0;
        pass_wr        = 1'b0;

        case (state_reg)
            xed_pkg::ST_IDLE: begin
                if (s_accept) begin
                    last_next     = s_tlast;
                    emit_cnt_next = '0;
                    if (!in_entity_reg) begin
                        if (s_tdata == xed_pkg::CH_AMP && !s_tlast) begin
                            in_entity_next = 1'b1;
                            count_next     = '0;
                        end else begin
                            pass_wr = 1'b1;
                        end
                    end else if (s_tdata == xed_pkg::CH_SEMI) begin
                        cnt_next  = CNT_W'(count_reg);
                        bidx_next = '0;
                        if (is_amp || is_lt || is_gt || is_quot || is_apos) begin
                            buf_len_next = 3'd1;
                            buf_next[0]  = is_amp ? xed_pkg::CH_AMP :
                                           is_lt  ? xed_pkg::CH_LT :
                                           is_gt  ? xed_pkg::CH_GT :
                                           is_quot ? xed_pkg::CH_QUOT : xed_pkg::CH_APOS;
                            state_next   = xed_pkg::ST_BUF;
                        end else if (is_nbsp) begin
                            buf_len_next = 3'd2;
                            buf_next[0]  = xed_pkg::NBSP_HI;
                            buf_next[1]  = xed_pkg::NBSP_LO;
                            state_next   = xed_pkg::ST_BUF;
                        end else if (count_reg != '0 && head[0] == xed_pkg::CH_HASH) begin
                            cp_ctrl.clear = 1'b1;
                            if (count_reg >= IDX_W'(2) && (head[1] == xed_pkg::CH_LX
                                    || head[1] == xed_pkg::CH_UX)) begin
                                hex_next    = 1'b1;
                                rd_ptr_next = IDX_W'(2);
                            end else begin
                                hex_next    = 1'b0;
                                rd_ptr_next = IDX_W'(1);
                            end
                            state_next = xed_pkg::ST_NUM;
                        end else begin
                            replay_next = 1'b0;
                            state_next  = xed_pkg::ST_AMP;
                        end
                    end else if (!s_tlast && (CNT_W'(count_reg) + CNT_W'(1))
                                 < CNT_W'(MAX_SCAN)) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + IDX_W'(1);
                    end else begin
                        wr_en       = 1'b1;
                        cnt_next    = CNT_W'(count_reg) + CNT_W'(1);
                        replay_next = 1'b1;
                        state_next  = xed_pkg::ST_AMP;
                    end
                end
            end
            xed_pkg::ST_NUM: begin
                if (num_done) begin
                    state_next = xed_pkg::ST_ENC;
                end else begin
                    cp_ctrl.step = 1'b1;
                    cp_ctrl.hex  = hex_reg;
                    rd_ptr_next  = rd_ptr_reg + IDX_W'(1);
                end
            end
            xed_pkg::ST_ENC: begin
                buf_next     = enc.bytes;
                buf_len_next = enc.len;
                bidx_next    = '0;
                state_next   = xed_pkg::ST_BUF;
            end
            xed_pkg::ST_BUF: begin
                emit_req   = 1'b1;
                emit_byte  = buf_reg[bidx_reg];
                emit_final = ({1'b0, bidx_reg} + 3'd1) == buf_len_reg;
                if (emit_go) begin
                    if (emit_final) begin
                        in_entity_next = 1'b0;
                        count_next     = '0;
                        state_next     = xed_pkg::ST_IDLE;
                    end else begin
                        bidx_next = bidx_reg + 2'd1;
                    end
                end
            end
            xed_pkg::ST_AMP: begin
                emit_req  = 1'b1;
                emit_byte = xed_pkg::CH_AMP;
                if (emit_go) begin
                    rd_ptr_next = '0;
                    state_next  = (cnt_reg == '0) ? xed_pkg::ST_SEMI : xed_pkg::ST_WIN;
                end
            end
            xed_pkg::ST_WIN: begin
                if (replay_reg && !last_reg && rd_data == xed_pkg::CH_AMP) begin
                    if (last_idx) begin
                        in_entity_next = 1'b1;
                        count_next     = '0;
                        state_next     = xed_pkg::ST_IDLE;
                    end else begin
                        rd_ptr_next = rd_ptr_reg + IDX_W'(1);
                        dst_next    = '0;
                        state_next  = xed_pkg::ST_COPY;
                    end
                end else begin
                    emit_req   = 1'b1;
                    emit_byte  = rd_data;
                    emit_final = replay_reg && last_idx;
                    if (emit_go) begin
                        if (last_idx) begin
                            if (replay_reg) begin
                                in_entity_next = 1'b0;
                                count_next     = '0;
                                state_next     = xed_pkg::ST_IDLE;
                            end else begin
                                state_next = xed_pkg::ST_SEMI;
                            end
                        end else begin
                            rd_ptr_next = rd_ptr_reg + IDX_W'(1);
                        end
                    end
                end
            end
            xed_pkg::ST_SEMI: begin
                emit_req   = 1'b1;
                emit_byte  = xed_pkg::CH_SEMI;
                emit_final = 1'b1;
                if (emit_go) begin
                    in_entity_next = 1'b0;
                    count_next     = '0;
                    state_next     = xed_pkg::ST_IDLE;
                end
            end
            xed_pkg::ST_COPY: begin
                wr_en   = 1'b1;
                wr_addr = dst_reg;
                wr_data = rd_data;
                if (last_idx) begin
                    in_entity_next = 1'b1;
                    count_next     = dst_reg + IDX_W'(1);
                    state_next     = xed_pkg::ST_IDLE;
                end else begin
                    rd_ptr_next = rd_ptr_reg + IDX_W'(1);
                    dst_next    = dst_reg + IDX_W'(1);
                end
            end
            default: begin
                state_next = xed_pkg::ST_IDLE;
            end
        endcase

        if (pass_wr) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = s_tdata;
            m_tlast_next  = s_tlast;
        end else if (emit_req && emit_go && !capped) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = emit_byte;
            m_tlast_next  = last_reg && (emit_final
                            || emit_cnt_reg == EW'(xed_pkg::RESULT_CAP - 1));
            emit_cnt_next = emit_cnt_reg + EW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= xed_pkg::ST_IDLE;
            in_entity_reg <= 1'b0;
            count_reg     <= '0;
            emit_cnt_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            in_entity_reg <= in_entity_next;
            count_reg     <= count_next;
            emit_cnt_reg  <= emit_cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg     <= cnt_next;
        rd_ptr_reg  <= rd_ptr_next;
        dst_reg     <= dst_next;
        replay_reg  <= replay_next;
        last_reg    <= last_next;
        hex_reg     <= hex_next;
        buf_reg     <= buf_next;
        buf_len_reg <= buf_len_next;
        bidx_reg    <= bidx_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `XED_ASSERT_IMPLY(a_idle_window_empty, st_idle && !in_entity_reg, count_reg == '0)
    `XED_ASSERT_HOLDS(a_count_in_range, CNT_W'(count_reg) < CNT_W'(MAX_SCAN))
    `XED_ASSERT_IMPLY(a_last_ends_entity, m_tvalid_reg && m_tlast_reg && st_idle, !in_entity_reg)

endmodule

// ===== verif/tb_top.sv =====
// testbench for xml_entity_decoder_top: random and directed strings with entities
// predicts the decoded byte stream in a scoreboard class, checks every m_ item
// depends on xed_pkg and the decoder rtl
`timescale 1ns / 100ps

typedef struct packed {
    logic [7:0] data;
    logic       last;
} dec_byte_t;

class decoded_stream_checker #(int SCAN = 12);
    logic [7:0] held [SCAN];
    int         held_cnt;
    bit         scanning;
    dec_byte_t  expected_bytes[$];
    dec_byte_t  step_bytes[$];
    int         errors;

    function new();
        held_cnt = 0;
        scanning = 0;
        errors = 0;
    endfunction

    function void emit(logic [7:0] b);
        dec_byte_t d;
        if (step_bytes.size() >= xed_pkg::RESULT_CAP) return;
        d.data = b;
        d.last = 1'b0;
        step_bytes.push_back(d);
    endfunction

    function bit body_is(string name);
        if (held_cnt != name.len()) return 0;
        for (int k = 0; k < held_cnt; k++)
            if (held[k] != name[k]) return 0;
        return 1;
    endfunction

    function logic [31:0] hex_digit(logic [7:0] c);
        if (c >= "0" && c <= "9") return {24'h0, c - 8'h30};
        if (c >= "a" && c <= "f") return {24'h0, c - 8'h57};
        if (c >= "A" && c <= "F") return {24'h0, c - 8'h37};
        return 32'h0;
    endfunction

    function void encode_utf8(logic [31:0] cp);
        if (cp < xed_pkg::CP_TWO_BYTE) begin
            emit(cp[7:0]);
        end else if (cp < xed_pkg::CP_THREE_BYTE) begin
            emit(xed_pkg::LEAD_TWO | 8'(cp >> 6));
            emit(xed_pkg::CONT_MARK | {2'b00, cp[5:0]});
        end else if (cp < xed_pkg::CP_FOUR_BYTE) begin
            emit(xed_pkg::LEAD_THREE | 8'(cp >> 12));
            emit(xed_pkg::CONT_MARK | {2'b00, cp[11:6]});
            emit(xed_pkg::CONT_MARK | {2'b00, cp[5:0]});
        end else begin
            emit(xed_pkg::LEAD_FOUR | 8'(cp >> 18));
            emit(xed_pkg::CONT_MARK | {2'b00, cp[17:12]});
            emit(xed_pkg::CONT_MARK | {2'b00, cp[11:6]});
            emit(xed_pkg::CONT_MARK | {2'b00, cp[5:0]});
        end
    endfunction

    function void close_entity();
        logic [31:0] cp;
        if (body_is("amp")) begin emit(xed_pkg::CH_AMP); return; end
        if (body_is("lt")) begin emit(xed_pkg::CH_LT); return; end
        if (body_is("gt")) begin emit(xed_pkg::CH_GT); return; end
        if (body_is("quot")) begin emit(xed_pkg::CH_QUOT); return; end
        if (body_is("apos")) begin emit(xed_pkg::CH_APOS); return; end
        if (body_is("nbsp")) begin
            emit(xed_pkg::NBSP_HI);
            emit(xed_pkg::NBSP_LO);
            return;
        end
        if (held_cnt > 0 && held[0] == xed_pkg::CH_HASH) begin
            cp = 32'h0;
            if (held_cnt >= 2 && (held[1] == xed_pkg::CH_LX
                    || held[1] == xed_pkg::CH_UX)) begin
                for (int k = 2; k < held_cnt; k++)
                    cp = (cp << 4) | hex_digit(held[k]);
            end else begin
                for (int k = 1; k < held_cnt; k++)
                    cp = cp * 32'd10 + ({24'h0, held[k]} - 32'h30);
            end
            encode_utf8(cp);
            return;
        end
        emit(xed_pkg::CH_AMP);
        for (int k = 0; k < held_cnt; k++)
            emit(held[k]);
        emit(xed_pkg::CH_SEMI);
    endfunction

    // failed scan: '&' goes out, held bytes and the current one are run again
    function void replay(logic [7:0] cur, bit last);
        logic [7:0] seq [SCAN + 1];
        int cnt;
        for (int k = 0; k < held_cnt; k++)
            seq[k] = held[k];
        seq[held_cnt] = cur;
        cnt = held_cnt + 1;
        scanning = 0;
        held_cnt = 0;
        emit(xed_pkg::CH_AMP);
        for (int k = 0; k < cnt; k++) begin
            if (!last && seq[k] == xed_pkg::CH_AMP) begin
                for (int m = k + 1; m < cnt; m++)
                    held[m - k - 1] = seq[m];
                held_cnt = cnt - k - 1;
                scanning = 1;
                return;
            end
            emit(seq[k]);
        end
    endfunction

    function void note_input(logic [7:0] b, bit last);
        dec_byte_t d;
        step_bytes.delete();
        if (!scanning) begin
            if (b == xed_pkg::CH_AMP && !last) begin
                scanning = 1;
                held_cnt = 0;
                return;
            end
            emit(b);
        end else if (b == xed_pkg::CH_SEMI) begin
            close_entity();
            scanning = 0;
            held_cnt = 0;
        end else if (!last && held_cnt + 1 < SCAN) begin
            held[held_cnt] = b;
            held_cnt++;
            return;
        end else begin
            replay(b, last);
        end
        if (last) begin
            scanning = 0;
            held_cnt = 0;
            if (step_bytes.size() > 0) begin
                d = step_bytes.pop_back();
                d.last = 1'b1;
                step_bytes.push_back(d);
            end
        end
        foreach (step_bytes[i])
            expected_bytes.push_back(step_bytes[i]);
    endfunction

    function void check_output(logic [7:0] b, logic last);
        dec_byte_t want;
        if (expected_bytes.size() == 0) begin
            $error("unexpected item: out_byte %h out_last %b", b, last);
            errors++;
            return;
        end
        want = expected_bytes.pop_front();
        if (b !== want.data) begin
            $error("out_byte expected %h actual %h", want.data, b);
            errors++;
        end
        if (last !== want.last) begin
            $error("out_last expected %b actual %b", want.last, last);
            errors++;
        end
    endfunction

    function int pending();
        return expected_bytes.size();
    endfunction
endclass

module tb_top;
    localparam int MAX_SCAN = 12;
    localparam int LIMIT    = 400000;
    localparam int RANDOM_ITEMS = 170;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PERIODIC
    } ready_mode_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    decoded_stream_checker #(MAX_SCAN) board;
    logic [7:0]  line_bytes[$];
    int          burst_left = 0;
    int          sent = 0;
    int          cycles = 0;
    int          mode_left = 0;
    ready_mode_t ready_mode = READY_ALWAYS;

    xml_entity_decoder_top #(.MAX_SCAN(MAX_SCAN)) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: stall pattern is picked at random from four modes
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_output(m_tdata, m_tlast);
        if (mode_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 120);
        end else begin
            mode_left--;
        end
        case (ready_mode)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
            READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:      m_tready <= (cycles % 5 < 3);
        endcase
    end

    task automatic send_item(input logic [7:0] b, input bit last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_input(b, last);
        sent++;
    endtask

    task automatic send_line();
        for (int i = 0; i < line_bytes.size(); i++)
            send_item(line_bytes[i], i == line_bytes.size() - 1);
        line_bytes.delete();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
    endtask

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_bytes.push_back(s[i]);
    endfunction

    function automatic logic [7:0] any_but_semi();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == xed_pkg::CH_SEMI) b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic void push_segment();
        string names[6] = '{"amp", "lt", "gt", "quot", "apos", "nbsp"};
        string hexset = "0123456789abcdefABCDEF";
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            line_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 45) begin
            push_text({"&", names[$urandom_range(0, 5)], ";"});
        end else if (pick < 60) begin
            push_text("&#");
            len = $urandom_range(0, 10);
            for (int i = 0; i < len; i++)
                line_bytes.push_back(($urandom_range(0, 7) == 0) ? any_but_semi()
                                     : 8'(8'h30 + $urandom_range(0, 9)));
            push_text(";");
        end else if (pick < 75) begin
            line_bytes.push_back(xed_pkg::CH_AMP);
            line_bytes.push_back(xed_pkg::CH_HASH);
            line_bytes.push_back($urandom_range(0, 1) ? xed_pkg::CH_LX : xed_pkg::CH_UX);
            len = $urandom_range(0, 9);
            for (int i = 0; i < len; i++)
                line_bytes.push_back(($urandom_range(0, 7) == 0) ? any_but_semi()
                                     : hexset[$urandom_range(0, 21)]);
            push_text(";");
        end else if (pick < 85) begin
            line_bytes.push_back(xed_pkg::CH_AMP);
            len = $urandom_range(0, MAX_SCAN - 1);
            for (int i = 0; i < len; i++)
                line_bytes.push_back(($urandom_range(0, 1) == 0) ? any_but_semi()
                                     : 8'(8'h61 + $urandom_range(0, 25)));
            line_bytes.push_back(xed_pkg::CH_SEMI);
        end else begin
            // no ';' in reach, may hold another '&' that starts a new scan
            line_bytes.push_back(xed_pkg::CH_AMP);
            len = (pick < 95) ? $urandom_range(MAX_SCAN - 1, MAX_SCAN + 2)
                              : $urandom_range(0, 5);
            for (int i = 0; i < len; i++)
                line_bytes.push_back(($urandom_range(0, 5) == 0) ? xed_pkg::CH_AMP
                                     : any_but_semi());
        end
    endfunction

    initial begin
        int segs;
        bit paused;
        board = new();
        paused = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        line_bytes.push_back(8'h00);
        line_bytes.push_back(8'hFF);
        push_text("&lt;&#;&;");
        send_line();
        push_text("&");
        send_line();
        push_text("&#x1F600;&ab");
        send_line();
        drain();

        while (sent < RANDOM_ITEMS) begin
            segs = $urandom_range(1, 6);
            for (int i = 0; i < segs; i++)
                push_segment();
            send_line();
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
                paused = 1;
                drain();
            end
        end
        s_tvalid <= 1'b0;

        while (board.pending() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
